// File: hdl/strs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer ring scheduler package
// Shared constants and types for the timer ring scheduler core.
// ----------------------------------------------------------------------------
package strs_pkg;

	localparam int TIMER_SLOTS = 32;
	localparam int SLOT_W = $clog2(TIMER_SLOTS);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [31:0] time_t;

	// Operation codes of a request.
	localparam logic [1:0] FUNC_ADD  = 2'd0;
	localparam logic [1:0] FUNC_DEL  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

endpackage

// File: hdl/strs_alu.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One 32-bit adder/subtractor shared by the steps of the sequencer.
// ----------------------------------------------------------------------------
module strs_alu
	import strs_pkg::*;
(
	input  alu_op_t op,
	input  time_t   a,
	input  time_t   b,
	output time_t   y
);

	// Add or subtract modulo 2^32.
	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule

// File: hdl/sorted_timer_ring_scheduler_core.sv
// ----------------------------------------------------------------------------
// Sorted timer ring scheduler core
// Keeps timer slots in a sorted ring and drives a one-shot match counter.
// ----------------------------------------------------------------------------
// Error results and plain ticks are given straight from idle; an add to an empty
// ring, a delete and an add to a non-empty ring pass through the sequencer states,
// the last walking past entries until the gap compare or the ring's end stops it.
// An expiry strobes one fired slot per cycle, the first once the fire state is entered.
// A new request can be taken while the last result is shown; no receiver stall.
// Reset clears link flags, head, counter and the sequencer at once.
module sorted_timer_ring_scheduler_core
	import strs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [4:0]  slot,
	input  logic [31:0] delay,
	output logic        strobe,
	output logic        status,
	output logic        fired_valid,
	output logic [4:0]  fired_slot,
	output logic        last
);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD0, S_ADD1, S_WALK0, S_WALK1, S_WALK2, S_LINK,
		S_DEL0, S_DEL1, S_FIRE0, S_DONE
	} state_t;

	state_t state_q;
	time_t  exp_q [TIMER_SLOTS];
	slot_t  next_q [TIMER_SLOTS];
	slot_t  prev_q [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] linked_q;
	slot_t  head_q, s_q, p_q;
	logic   empty_q, counting_q;
	time_t  tick_q, match_q, delay_q, t_q, left_q, a_q, x_q;
	logic [SLOT_W:0] cnt_q;

	alu_op_t op;
	time_t   aa, bb, yy;

	strs_alu u_alu (.op(op), .a(aa), .b(bb), .y(yy));

	// Operand selection for the shared adder.
	always_comb begin
		op = ALU_SUB;
		aa = match_q;
		bb = tick_q;
		unique case (state_q)
			S_ADD1: begin op = ALU_SUB; aa = x_q; bb = left_q; end
			S_WALK0: begin op = ALU_SUB; aa = t_q; bb = exp_q[p_q]; end
			S_WALK1: begin op = ALU_SUB; aa = exp_q[next_q[p_q]]; bb = exp_q[p_q]; end
			S_DEL0: begin op = ALU_SUB; aa = exp_q[next_q[s_q]]; bb = exp_q[s_q]; end
			S_DEL1: begin op = ALU_ADD; aa = x_q; bb = left_q; end
			S_FIRE0: begin op = ALU_SUB; aa = exp_q[next_q[head_q]]; bb = t_q; end
			S_IDLE: begin
				if (func == FUNC_TICK) begin
					op = ALU_ADD; aa = tick_q; bb = 32'd1;
				end else begin
					op = ALU_SUB; aa = match_q; bb = tick_q;
				end
			end
			S_ADD0: begin op = ALU_ADD; aa = exp_q[head_q]; bb = delay_q; end
			default: begin op = ALU_SUB; aa = match_q; bb = tick_q; end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// Sequencer with ring storage and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			linked_q <= '0;
			head_q <= '0;
			empty_q <= 1'b1;
			counting_q <= 1'b0;
			tick_q <= '0;
			match_q <= '0;
			strobe <= 1'b0;
			status <= 1'b0;
			fired_valid <= 1'b0;
			fired_slot <= '0;
			last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						s_q <= slot[SLOT_W-1:0];
						delay_q <= delay;
						status <= 1'b0;
						fired_valid <= 1'b0;
						fired_slot <= '0;
						last <= 1'b1;
						left_q <= yy;
						if (func == FUNC_TICK) begin
							if (counting_q && (yy == match_q || match_q == '0)) begin
								tick_q <= '0;
								counting_q <= 1'b0;
								if (empty_q) begin
									strobe <= 1'b1;
								end else begin
									t_q <= exp_q[head_q];
									state_q <= S_FIRE0;
								end
							end else begin
								if (counting_q) tick_q <= yy;
								strobe <= 1'b1;
							end
						end else if (func == FUNC_ADD) begin
							if (linked_q[slot[SLOT_W-1:0]]) begin
								status <= 1'b1;
								strobe <= 1'b1;
							end else begin
								state_q <= S_ADD0;
							end
						end else if (func == FUNC_DEL) begin
							if (!linked_q[slot[SLOT_W-1:0]]) begin
								status <= 1'b1;
								strobe <= 1'b1;
							end else begin
								state_q <= S_DEL0;
							end
						end else begin
							status <= 1'b1;
							strobe <= 1'b1;
						end
					end
				end
				S_ADD0: begin
					linked_q[s_q] <= 1'b1;
					if (empty_q) begin
						exp_q[s_q] <= delay_q;
						next_q[s_q] <= s_q;
						prev_q[s_q] <= s_q;
						head_q <= s_q;
						empty_q <= 1'b0;
						tick_q <= '0;
						match_q <= delay_q;
						counting_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						x_q <= yy;
						state_q <= S_ADD1;
					end
				end
				S_ADD1: begin
					t_q <= yy;
					exp_q[s_q] <= yy;
					p_q <= head_q;
					cnt_q <= '0;
					state_q <= S_WALK0;
				end
				S_WALK0: begin
					if (next_q[p_q] == head_q || cnt_q == (SLOT_W+1)'(TIMER_SLOTS))
						state_q <= S_LINK;
					else begin
						a_q <= yy;
						state_q <= S_WALK1;
					end
				end
				S_WALK1: begin
					if (a_q <= yy) state_q <= S_LINK;
					else state_q <= S_WALK2;
				end
				S_WALK2: begin
					p_q <= next_q[p_q];
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_WALK0;
				end
				S_LINK: begin
					next_q[s_q] <= next_q[p_q];
					prev_q[s_q] <= p_q;
					prev_q[next_q[p_q]] <= s_q;
					next_q[p_q] <= s_q;
					if (left_q > delay_q) begin
						head_q <= s_q;
						tick_q <= '0;
						match_q <= delay_q;
						counting_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DEL0: begin
					x_q <= yy;
					state_q <= S_DEL1;
				end
				S_DEL1: begin
					if (s_q == head_q) begin
						if (next_q[s_q] == s_q) begin
							counting_q <= 1'b0;
							tick_q <= '0;
							empty_q <= 1'b1;
						end else begin
							head_q <= next_q[s_q];
							tick_q <= '0;
							match_q <= yy;
							counting_q <= 1'b1;
						end
					end
					next_q[prev_q[s_q]] <= next_q[s_q];
					prev_q[next_q[s_q]] <= prev_q[s_q];
					linked_q[s_q] <= 1'b0;
					exp_q[s_q] <= '0;
					state_q <= S_DONE;
				end
				S_FIRE0: begin
					// Emit the head, unlink it and check whether the next slot shares its time.
					strobe <= 1'b1;
					fired_valid <= 1'b1;
					fired_slot <= 5'(head_q);
					linked_q[head_q] <= 1'b0;
					if (next_q[head_q] == head_q) begin
						empty_q <= 1'b1;
						last <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						next_q[prev_q[head_q]] <= next_q[head_q];
						prev_q[next_q[head_q]] <= prev_q[head_q];
						head_q <= next_q[head_q];
						if (yy != '0) begin
							tick_q <= '0;
							match_q <= yy;
							counting_q <= 1'b1;
							last <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							last <= 1'b0;
						end
					end
				end
				S_DONE: begin
					strobe <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// An error result never reports a fired slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> !fired_valid)
		else $error("error result with fired slot");
	// An empty ring leaves the counter stopped after a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && empty_q |-> !counting_q)
		else $error("counter running on empty ring");
	// A result is only produced while handling a request or at its close.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) != S_IDLE || $past(start))
		else $error("spurious result");

endmodule
